FILE: src/clrs_pkg.sv
// Shared types and constants for the callsign lookup block.
// No dependencies; imported by every other file of the block but clrs_ram.
package clrs_pkg;

   // Field widths fixed by the port list
   localparam int KEY_W       = 24;
   localparam int ENTRY_IDX_W = 6;
   localparam int HIT_OUT_W   = 16;

   // Default sizing
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int WINDOW_LEN_DEF  = 8;
   localparam int HIT_BITS_DEF    = 16;

   // Request opcodes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // Control from the sequencer to the recent window
   typedef struct packed {
      logic age;     // shift by one slot, newest slot emptied
      logic insert;  // write the query index into the newest slot
   } win_ctrl_type;

endpackage

FILE: src/clrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: src/clrs_window.sv
// Recent-display window: shift line of WINDOW_LEN+1 slots of valid + index.
// Depends on clrs_pkg (win_ctrl_type).
module clrs_window #(
   parameter int WINDOW_LEN = 8,
   parameter int IDX_W      = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  clrs_pkg::win_ctrl_type    ctrl,
   input  logic [IDX_W-1:0]          query_idx,
   output logic                      in_window
);
   import clrs_pkg::*;

   localparam int SLOTS = WINDOW_LEN + 1;

   logic             used_ff [SLOTS];
   logic             used_in [SLOTS];
   logic [IDX_W-1:0] idx_ff  [SLOTS];
   logic [IDX_W-1:0] idx_in  [SLOTS];
   logic [SLOTS-1:0] slot_hit;

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         used_in[s] = used_ff[s];
         idx_in[s]  = idx_ff[s];
      end
      if (ctrl.age) begin
         for (int s = SLOTS - 1; s >= 1; s--) begin
            used_in[s] = used_ff[s-1];
            idx_in[s]  = idx_ff[s-1];
         end
         used_in[0] = 1'b0;
         idx_in[0]  = '0;
      end else if (ctrl.insert) begin
         used_in[0] = 1'b1;
         idx_in[0]  = query_idx;
      end
   end

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_hit[s] = used_ff[s] && (idx_ff[s] == query_idx);
      end
   end

   assign in_window = |slot_hit;

   always_ff @(posedge clock) begin
      for (int s = 0; s < SLOTS; s++) begin
         idx_ff[s] <= idx_in[s];
         if (reset) begin
            used_ff[s] <= 1'b0;
         end else begin
            used_ff[s] <= used_in[s];
         end
      end
   end

endmodule

FILE: src/callsign_lookup_recent_suppress.sv
// Top level: key table lookup with hit counting and recent-display suppression.
// Depends on clrs_pkg, clrs_ram and clrs_window.
//
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------------------------
//  request   | start / busy        | req_op, req_key, req_entry_index
//  result    | rsp_strobe (1 cyc)  | rsp_found, rsp_match_index, rsp_show_name,
//            |                     | rsp_hit_total
//
// A request is taken when start is high and busy low.
// Load: written at once; its all-zero result strobes in the next cycle and a new
//   request may be taken in that same cycle.
// Lookup: one key RAM read per cycle through a single comparator. Busy stays high
//   while the table is scanned up to the first hit or the last slot, and on a hit
//   through the hit counter read and write; the result strobes in the same cycle that busy drops.
// After reset a clearing pass writes each key RAM slot in turn and so zeroes the
//   valid bits held in the key RAM; busy is high throughout.
// The receiver cannot stall: every result is shown for one cycle only.
module callsign_lookup_recent_suppress #(
   parameter int TABLE_DEPTH = clrs_pkg::TABLE_DEPTH_DEF,
   parameter int WINDOW_LEN  = clrs_pkg::WINDOW_LEN_DEF,
   parameter int HIT_BITS    = clrs_pkg::HIT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic [clrs_pkg::KEY_W-1:0]       req_key,
   input  logic [clrs_pkg::ENTRY_IDX_W-1:0] req_entry_index,
   // result channel
   output logic                             rsp_strobe,
   output logic                             rsp_found,
   output logic [clrs_pkg::ENTRY_IDX_W-1:0] rsp_match_index,
   output logic                             rsp_show_name,
   output logic [clrs_pkg::HIT_OUT_W-1:0]   rsp_hit_total
);
   import clrs_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

   // one-hot sequencer
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,  // sweeping valid bits after reset
      ST_IDLE   = 5'b00010,
      ST_SCAN   = 5'b00100,  // one table entry compared per cycle
      ST_HIT_RD = 5'b01000,  // hit counter read issued
      ST_HIT_WR = 5'b10000   // counter bumped, window checked, result built
   } state_type;

   state_type        state_ff, state_in;
   logic [IW-1:0]    clr_addr_ff, clr_addr_in;
   logic [IW-1:0]    scan_addr_ff, scan_addr_in;   // address being read
   logic [IW-1:0]    data_idx_ff, data_idx_in;     // slot of the data now on rd_data
   logic             pend_ff, pend_in;             // rd_data holds a scanned entry
   logic [IW-1:0]    hit_idx_ff, hit_idx_in;
   logic [KEY_W-1:0] key_ff, key_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [IW-1:0]        rsp_idx_ff, rsp_idx_in;
   logic                 rsp_show_ff, rsp_show_in;
   logic [HIT_BITS-1:0]  rsp_hits_ff, rsp_hits_in;

   // key RAM: {valid, key}
   logic             key_we;
   logic [IW-1:0]    key_waddr;
   logic [KEY_W:0]   key_wdata;
   logic [KEY_W:0]   key_rdata;
   // hit counter RAM
   logic                hit_we;
   logic [IW-1:0]       hit_waddr;
   logic [HIT_BITS-1:0] hit_wdata;
   logic [HIT_BITS-1:0] hit_rdata;
   logic [HIT_BITS-1:0] hit_next;

   logic         accept;
   logic         load_ok;
   logic         key_match;
   logic         in_window;
   win_ctrl_type win_ctrl;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   // loads to slots past the table are dropped but still answered
   assign load_ok = accept && (req_op == OP_LOAD)
                    && (32'(req_entry_index) < 32'(TABLE_DEPTH));

   assign key_match = pend_ff && key_rdata[KEY_W] && (key_rdata[KEY_W-1:0] == key_ff);

   // saturating increment
   assign hit_next = (hit_rdata == '1) ? hit_rdata : hit_rdata + 1'b1;

   // key RAM write: clearing pass or a load
   always_comb begin
      priority if (state_ff == ST_CLEAR) begin
         key_we    = 1'b1;
         key_waddr = clr_addr_ff;
         key_wdata = '0;
      end else begin
         key_we    = load_ok;
         key_waddr = IW'(req_entry_index);
         key_wdata = {1'b1, req_key};
      end
   end

   // hit RAM write: a load clears the count, a hit stores the bumped count.
   // Unloaded entries are never read, so no clearing pass is needed here.
   always_comb begin
      priority if (load_ok) begin
         hit_we    = 1'b1;
         hit_waddr = IW'(req_entry_index);
         hit_wdata = '0;
      end else begin
         hit_we    = (state_ff == ST_HIT_WR);
         hit_waddr = hit_idx_ff;
         hit_wdata = hit_next;
      end
   end

   // window is aged as the lookup is taken; insert only when not already there
   assign win_ctrl.age    = accept && (req_op == OP_LOOKUP);
   assign win_ctrl.insert = (state_ff == ST_HIT_WR) && !in_window;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      scan_addr_in  = scan_addr_ff;
      data_idx_in   = data_idx_ff;
      pend_in       = pend_ff;
      hit_idx_in    = hit_idx_ff;
      key_in        = key_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_idx_in    = '0;
      rsp_show_in   = 1'b0;
      rsp_hits_in   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  rsp_strobe_in = 1'b1;   // all-zero answer
               end else begin
                  key_in       = req_key;
                  scan_addr_in = '0;
                  pend_in      = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (key_match) begin
               hit_idx_in = data_idx_ff;
               state_in   = ST_HIT_RD;
            end else if (pend_ff && (data_idx_ff == LAST_IDX)) begin
               rsp_strobe_in = 1'b1;      // miss
               state_in      = ST_IDLE;
            end else begin
               data_idx_in = scan_addr_ff;
               pend_in     = 1'b1;
               if (scan_addr_ff != LAST_IDX) begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
         end
         ST_HIT_RD: begin
            state_in = ST_HIT_WR;
         end
         ST_HIT_WR: begin
            rsp_strobe_in = 1'b1;
            rsp_found_in  = 1'b1;
            rsp_idx_in    = hit_idx_ff;
            rsp_show_in   = !in_window;
            rsp_hits_in   = hit_next;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      scan_addr_ff <= scan_addr_in;
      data_idx_ff  <= data_idx_in;
      hit_idx_ff   <= hit_idx_in;
      key_ff       <= key_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_show_ff  <= rsp_show_in;
      rsp_hits_ff  <= rsp_hits_in;
   end

   clrs_ram #(
      .WIDTH (KEY_W + 1),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (scan_addr_ff),
      .rd_data (key_rdata)
   );

   clrs_ram #(
      .WIDTH (HIT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_hit_ram (
      .clock   (clock),
      .wr_en   (hit_we),
      .wr_addr (hit_waddr),
      .wr_data (hit_wdata),
      .rd_addr (hit_idx_ff),
      .rd_data (hit_rdata)
   );

   clrs_window #(
      .WINDOW_LEN (WINDOW_LEN),
      .IDX_W      (IW)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .query_idx (hit_idx_ff),
      .in_window (in_window)
   );

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = ENTRY_IDX_W'(rsp_idx_ff);
   assign rsp_show_name   = rsp_show_ff;
   assign rsp_hit_total   = HIT_OUT_W'(rsp_hits_ff);

endmodule

FILE: src/clrs_checker.sv
// Port-level checks for the callsign lookup block, bound to the top level.
// Depends on clrs_pkg and callsign_lookup_recent_suppress.
module clrs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             req_op,
   input logic                             rsp_strobe,
   input logic                             rsp_found,
   input logic [clrs_pkg::ENTRY_IDX_W-1:0] rsp_match_index,
   input logic                             rsp_show_name,
   input logic [clrs_pkg::HIT_OUT_W-1:0]   rsp_hit_total
);
   import clrs_pkg::*;

   // a miss carries an all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |->
         (rsp_match_index == '0) && !rsp_show_name && (rsp_hit_total == '0))
      else $error("miss result with non-zero payload");

   // only a found entry can be shown
   a_show_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_show_name |-> rsp_found)
      else $error("show without a match");

   // a load answers in the next cycle with found low
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_LOAD) |=> rsp_strobe && !rsp_found)
      else $error("load request not answered next cycle");

   // a lookup occupies the block and gives no result in the next cycle
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_LOOKUP) |=> busy && !rsp_strobe)
      else $error("lookup request did not make the block busy");

endmodule

bind callsign_lookup_recent_suppress clrs_checker u_clrs_checker (.*);

FILE: verif/tb_callsign_lookup_recent_suppress.sv
// Self-checking bench for callsign_lookup_recent_suppress: directed and random requests,
// each reply checked against a behavioural copy of the key table and the recent window.
// Depends on clrs_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_callsign_lookup_recent_suppress;
   import clrs_pkg::*;

   // Sizing follows the block's defaults, which is how it is instantiated below
   localparam int TBL_DEPTH   = TABLE_DEPTH_DEF;
   localparam int WIN_SLOTS   = WINDOW_LEN_DEF + 1;
   localparam int HIT_W       = HIT_BITS_DEF;
   localparam int STALL_LIMIT = 1000;  // well above a miss scan plus the clearing pass
   localparam int POOL_SIZE   = 10;
   localparam int HIT_REPEATS = 20;

   typedef struct packed {
      logic                   found;
      logic [ENTRY_IDX_W-1:0] match_index;
      logic                   show_name;
      logic [HIT_OUT_W-1:0]   hit_total;
   } station_reply_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_op = OP_LOOKUP;
   logic [KEY_W-1:0]       req_key = '0;
   logic [ENTRY_IDX_W-1:0] req_entry_index = '0;
   logic                   rsp_strobe;
   logic                   rsp_found;
   logic [ENTRY_IDX_W-1:0] rsp_match_index;
   logic                   rsp_show_name;
   logic [HIT_OUT_W-1:0]   rsp_hit_total;

   // Behavioural copy of the block's state
   logic [KEY_W-1:0]       key_tab   [TBL_DEPTH];
   logic                   entry_ok  [TBL_DEPTH];
   logic [HIT_W-1:0]       hit_cnt   [TBL_DEPTH];
   logic                   win_used  [WIN_SLOTS];
   int                     win_entry [WIN_SLOTS];

   station_reply_type pending_replies[$];
   int             fail_count  = 0;
   int             idle_cycles = 0;
   bit             gaps_on     = 1'b1;
   logic [KEY_W-1:0] call_pool [POOL_SIZE];

   callsign_lookup_recent_suppress u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_entry_index (req_entry_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .rsp_show_name   (rsp_show_name),
      .rsp_hit_total   (rsp_hit_total)
   );

   always #2 clock = ~clock;

   // Applies one request to the state copy and returns the reply the block owes for it.
   function automatic station_reply_type lookup_reply(input logic op,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [ENTRY_IDX_W-1:0] slot);
      station_reply_type res;
      int             hit_slot;
      bit             in_window;
      res       = '0;
      hit_slot  = -1;
      in_window = 1'b0;
      if (op == OP_LOAD) begin
         // load leaves the window alone; reply is all zero
         if (int'(slot) < TBL_DEPTH) begin
            key_tab[slot]  = key;
            entry_ok[slot] = 1'b1;
            hit_cnt[slot]  = '0;
         end
         return res;
      end
      // every lookup ages the window, hit or miss
      for (int i = WIN_SLOTS - 1; i > 0; i--) begin
         win_used[i]  = win_used[i-1];
         win_entry[i] = win_entry[i-1];
      end
      win_used[0]  = 1'b0;
      win_entry[0] = 0;
      // lowest valid slot with the key wins
      for (int i = 0; i < TBL_DEPTH; i++) begin
         if (entry_ok[i] && key_tab[i] == key) begin
            hit_slot = i;
            break;
         end
      end
      if (hit_slot < 0)
         return res;
      if (hit_cnt[hit_slot] != '1)
         hit_cnt[hit_slot] = hit_cnt[hit_slot] + 1'b1;
      for (int i = 0; i < WIN_SLOTS; i++)
         if (win_used[i] && win_entry[i] == hit_slot)
            in_window = 1'b1;
      if (!in_window) begin
         win_used[0]  = 1'b1;
         win_entry[0] = hit_slot;
      end
      res.found       = 1'b1;
      res.match_index = hit_slot[ENTRY_IDX_W-1:0];
      res.show_name   = !in_window;
      res.hit_total   = hit_cnt[hit_slot][HIT_OUT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string field, input longint want, input longint got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   // Compares the reply on the ports with the oldest one owed.
   task automatic check_reply();
      station_reply_type want;
      if (pending_replies.size() == 0) begin
         fail_count++;
         $display("%0t: reply strobed with none owed, expected none, actual %0h/%0h/%0h/%0h",
                  $time, rsp_found, rsp_match_index, rsp_show_name, rsp_hit_total);
         return;
      end
      want = pending_replies.pop_front();
      if (rsp_found !== want.found)
         report_mismatch("found", want.found, rsp_found);
      if (rsp_match_index !== want.match_index)
         report_mismatch("match_index", want.match_index, rsp_match_index);
      if (rsp_show_name !== want.show_name)
         report_mismatch("show_name", want.show_name, rsp_show_name);
      if (rsp_hit_total !== want.hit_total)
         report_mismatch("hit_total", want.hit_total, rsp_hit_total);
   endtask

   // Sampling at the rising edge: the reply of an earlier request is checked before a
   // request taken at the same edge is predicted, which keeps the order right.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            check_reply();
         if (start && !busy)
            pending_replies.push_back(lookup_reply(req_op, req_key, req_entry_index));
         if (rsp_strobe || (start && !busy))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Drives one request at a falling edge and returns at the rising edge that takes it.
   // start stays high on return until a later gap or the end of the run lowers it.
   task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                               input logic [ENTRY_IDX_W-1:0] index);
      int gap;
      gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_op          <= op;
      req_key         <= key;
      req_entry_index <= index;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_lookup(input logic [KEY_W-1:0] key);
      send_request(OP_LOOKUP, key, ENTRY_IDX_W'($urandom));
   endtask

   // Fresh table: nothing can match, whatever the key
   task automatic test_empty_table();
      send_lookup(24'h000000);
      send_lookup(24'hFFFFFF);
      send_request(OP_LOOKUP, "ABC", '1);
   endtask

   // Extreme keys in the extreme slots; a second lookup is suppressed
   task automatic test_load_and_lookup();
      send_request(OP_LOAD, 24'hFFFFFF, '0);
      send_request(OP_LOAD, 24'h000000, '1);
      send_request(OP_LOOKUP, 24'h000000, '0);
      send_request(OP_LOOKUP, 24'hFFFFFF, '1);
      send_lookup(24'hFFFFFF);
   endtask

   // Same key in two slots: lower slot must win
   task automatic test_duplicate_keys();
      send_request(OP_LOAD, "K1A", 6'd40);
      send_request(OP_LOAD, "K1A", 6'd7);
      send_lookup("K1A");
   endtask

   // Slot 7 is now in the window, so a new key loaded there stays suppressed
   // until the window entry ages out after WIN_SLOTS lookups.
   task automatic test_reload_and_ageing();
      send_request(OP_LOAD, "W2X", 6'd7);
      for (int i = 0; i < WIN_SLOTS + 1; i++)
         send_lookup("W2X");
   endtask

   // Repeated hits on slot 0 count up, then check a reload clears the count.
   task automatic test_hit_counting();
      gaps_on = 1'b0;
      send_request(OP_LOAD, "SAT", '0);
      for (int i = 0; i < HIT_REPEATS; i++)
         send_lookup("SAT");
      send_request(OP_LOAD, "SAT", '0);
      send_lookup("SAT");
      gaps_on = 1'b1;
   endtask

   // Mostly lookups of a small pool of calls, so hits, suppression and ageing all
   // occur often; some loads shuffle the table and a few random keys give misses.
   task automatic test_random_traffic(input int n_items);
      int                     pick;
      logic [ENTRY_IDX_W-1:0] slot;
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(0, 19) == 0)
            call_pool[$urandom_range(0, POOL_SIZE - 1)] = KEY_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            // low slots keep hit scans short; the rest may land anywhere up to the top of the table
            slot = ($urandom_range(0, 3) != 0) ? ENTRY_IDX_W'($urandom_range(0, 15))
                                               : ENTRY_IDX_W'($urandom);
            if ($urandom_range(0, 4) == 0)
               send_request(OP_LOAD, KEY_W'($urandom), slot);
            else
               send_request(OP_LOAD, call_pool[$urandom_range(0, POOL_SIZE - 1)], slot);
         end else if (pick < 88)
            send_lookup(call_pool[$urandom_range(0, POOL_SIZE - 1)]);
         else
            send_lookup(KEY_W'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++)
         call_pool[i] = KEY_W'($urandom);
      for (int i = 0; i < TBL_DEPTH; i++) begin
         key_tab[i]  = '0;
         entry_ok[i] = 1'b0;
         hit_cnt[i]  = '0;
      end
      for (int i = 0; i < WIN_SLOTS; i++) begin
         win_used[i]  = 1'b0;
         win_entry[i] = 0;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_load_and_lookup();
      test_duplicate_keys();
      test_reload_and_ageing();
      test_hit_counting();
      test_random_traffic(900);
      gaps_on = 1'b0;  // closing stretch runs back to back
      test_random_traffic(250);

      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0)
         @(negedge clock);
      // room for any stray reply after a full miss scan
      repeat (TBL_DEPTH + 8) @(negedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
src/clrs_pkg.sv
src/clrs_ram.sv
src/clrs_window.sv
src/callsign_lookup_recent_suppress.sv
src/clrs_checker.sv
verif/tb_callsign_lookup_recent_suppress.sv
